@@ hw/rtl/utf8_to_latin1_cp1251_filter_unit_assert.svh @@
// Assertion macros for the UTF-8 to Latin-1 / Windows-1251 filter.
// Included by the top level; relies on clk and rst being in scope.
`ifndef UTF8_TO_LATIN1_CP1251_FILTER_UNIT_ASSERT_SVH
`define UTF8_TO_LATIN1_CP1251_FILTER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define U8FLT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define U8FLT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ hw/rtl/u8flt_pkg.sv @@
// Shared types, constants and the character conversion function of the filter.
// No dependencies.
`default_nettype none

package u8flt_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] BACKSLASH   = 8'h5c;
  localparam logic [7:0] ERASED      = 8'h1f;
  localparam logic [7:0] DQUOTE      = 8'h22;
  localparam logic [7:0] APOSTROPHE  = 8'h27;
  localparam logic [7:0] QUESTION    = 8'h3f;
  localparam logic [7:0] SLASH       = 8'h2f;
  localparam logic [7:0] LATIN_LO    = 8'hc2;
  localparam logic [7:0] LATIN_HI    = 8'hc3;
  localparam logic [7:0] CYR_LO      = 8'hd0;
  localparam logic [7:0] CYR_HI      = 8'hd3;
  localparam logic [10:0] CYR_MAX    = 11'h491;
  localparam logic [10:0] LATIN_LIM  = 11'h100;
  localparam logic [7:0] CYR_OFFSET  = 8'h50;
  localparam int unsigned CYR_EXC_N  = 29;

  localparam logic [10:0] CYR_CODE [CYR_EXC_N] = '{
    11'h401, 11'h402, 11'h403, 11'h404, 11'h405, 11'h406, 11'h407, 11'h408,
    11'h409, 11'h40a, 11'h40b, 11'h40c, 11'h40e, 11'h40f, 11'h452, 11'h451,
    11'h453, 11'h454, 11'h455, 11'h456, 11'h457, 11'h458, 11'h459, 11'h45a,
    11'h45b, 11'h45c, 11'h45f, 11'h490, 11'h491
  };
  localparam logic [7:0] CYR_BYTE [CYR_EXC_N] = '{
    8'ha8, 8'h80, 8'h81, 8'haa, 8'hbd, 8'h49, 8'haf, 8'ha3,
    8'h8a, 8'h8c, 8'h8e, 8'h8d, 8'ha1, 8'h8f, 8'h90, 8'hb8,
    8'h83, 8'hba, 8'hbe, 8'h69, 8'hbf, 8'h6a, 8'h9a, 8'h9c,
    8'h9e, 8'h9d, 8'h9f, 8'ha5, 8'hb4
  };

  // One output character: either a byte passed on as it is, or a UTF-8 lead
  // with its continuation byte still to be converted.
  typedef struct packed {
    logic       conv;
    logic [7:0] lead;
    logic [7:0] data;
  } slot_t;

  typedef struct packed {
    slot_t s0;
    slot_t s1;
    logic  two;
    logic  last;
    logic  cyr;
  } entry_t;

  typedef struct packed {
    logic hold_bs;
    logic hold_lead;
  } front_status_t;

  function automatic logic [7:0] utf8_convert(input logic [7:0] lead,
                                              input logic [7:0] cont);
    logic [10:0] code;
    logic [7:0]  res;
    code = {lead[4:0], cont[5:0]};
    res  = code[7:0] - CYR_OFFSET;
    if (lead <= LATIN_HI) begin
      res = (code >= LATIN_LIM) ? ERASED : code[7:0];
    end else if (code > CYR_MAX) begin
      res = ERASED;
    end else begin
      for (int i = 0; i < CYR_EXC_N; i++) begin
        if (code == CYR_CODE[i]) begin
          res = CYR_BYTE[i];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/u8flt_front.sv @@
// Input side of the filter: escape and UTF-8 lead tracking, builds queue entries.
// Depends on u8flt_pkg.
`default_nettype none

module u8flt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                in_byte,
  input  logic                      is_last,
  input  logic                      clear_flag,
  input  logic                      q_full,
  output logic                      push,
  output u8flt_pkg::entry_t         entry,
  output u8flt_pkg::front_status_t  status
);
  import u8flt_pkg::*;

  logic       held_backslash;
  logic       held_lead_valid;
  logic [7:0] held_lead;
  logic       cyrillic_flag;

  logic       held_backslash_next;
  logic       held_lead_valid_next;
  logic [7:0] held_lead_next;
  logic       cyrillic_flag_next;

  logic       accept;
  logic       flag_c;
  logic       b_esc;
  logic       b_lead;
  logic       b_bs;
  logic       f_emit;
  logic       f_hold_bs;
  logic       f_hold_lead;
  slot_t      f_slot;
  slot_t      raw_b;
  slot_t      s0;
  slot_t      s1;
  logic       any;
  logic       two;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && any;
  assign status   = '{hold_bs: held_backslash, hold_lead: held_lead_valid};

  always_comb begin
    flag_c = clear_flag ? 1'b0 : cyrillic_flag;
    b_bs   = (in_byte == BACKSLASH);
    b_esc  = (in_byte == DQUOTE) || (in_byte == APOSTROPHE) || b_bs ||
             (in_byte == QUESTION) || (in_byte == SLASH);
    b_lead = ((in_byte >= LATIN_LO) && (in_byte <= LATIN_HI)) ||
             ((in_byte >= CYR_LO) && (in_byte <= CYR_HI));
    raw_b  = '{conv: 1'b0, lead: in_byte, data: in_byte};

    // Handling of a byte that starts afresh.
    f_emit      = 1'b1;
    f_hold_bs   = 1'b0;
    f_hold_lead = 1'b0;
    f_slot      = raw_b;
    if (b_bs) begin
      if (!is_last) begin
        f_emit    = 1'b0;
        f_hold_bs = 1'b1;
      end
    end else if (b_lead) begin
      if (is_last) begin
        f_slot = '{conv: 1'b1, lead: in_byte, data: 8'h00};
      end else begin
        f_emit      = 1'b0;
        f_hold_lead = 1'b1;
      end
    end

    s0                   = f_slot;
    s1                   = f_slot;
    any                  = 1'b0;
    two                  = 1'b0;
    held_backslash_next  = held_backslash;
    held_lead_valid_next = held_lead_valid;
    held_lead_next       = in_byte;

    if (held_lead_valid && held_backslash) begin
      any = 1'b1;
      s0  = '{conv: 1'b1, lead: held_lead, data: b_esc ? ERASED : BACKSLASH};
      if (b_esc) begin
        s1                   = raw_b;
        two                  = 1'b1;
        held_backslash_next  = 1'b0;
        held_lead_valid_next = 1'b0;
      end else begin
        two                  = f_emit;
        held_backslash_next  = f_hold_bs;
        held_lead_valid_next = f_hold_lead;
      end
    end else if (held_lead_valid) begin
      held_lead_next = held_lead;
      if (b_bs && !is_last) begin
        held_backslash_next = 1'b1;
      end else begin
        any                  = 1'b1;
        s0                   = '{conv: 1'b1, lead: held_lead, data: in_byte};
        held_lead_valid_next = 1'b0;
      end
    end else if (held_backslash) begin
      any = 1'b1;
      if (b_esc) begin
        s0                  = '{conv: 1'b0, lead: ERASED, data: ERASED};
        s1                  = raw_b;
        two                 = 1'b1;
        held_backslash_next = 1'b0;
      end else begin
        s0                   = '{conv: 1'b0, lead: BACKSLASH, data: BACKSLASH};
        two                  = f_emit;
        held_backslash_next  = f_hold_bs;
        held_lead_valid_next = f_hold_lead;
      end
    end else begin
      any                  = f_emit;
      held_backslash_next  = f_hold_bs;
      held_lead_valid_next = f_hold_lead;
    end

    cyrillic_flag_next = flag_c ||
                         (any && s0.conv && (s0.lead >= CYR_LO)) ||
                         (two && s1.conv && (s1.lead >= CYR_LO));
    entry = '{s0: s0, s1: s1, two: two, last: is_last, cyr: cyrillic_flag_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_backslash  <= 1'b0;
      held_lead_valid <= 1'b0;
      held_lead       <= 8'h00;
      cyrillic_flag   <= 1'b0;
    end else if (accept) begin
      held_backslash  <= held_backslash_next;
      held_lead_valid <= held_lead_valid_next;
      held_lead       <= held_lead_next;
      cyrillic_flag   <= cyrillic_flag_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/u8flt_queue.sv @@
// Short first-in first-out queue of entries between the front and back parts.
// Depends on u8flt_pkg.
`default_nettype none

module u8flt_queue #(
  parameter int unsigned Depth = u8flt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8flt_pkg::entry_t  push_entry,
  input  logic               pop,
  output u8flt_pkg::entry_t  head,
  output logic               full,
  output logic               empty
);
  import u8flt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/u8flt_back.sv @@
// Output side of the filter: converts each character of an entry and drives
// the registered output stream. Depends on u8flt_pkg.
`default_nettype none

module u8flt_back (
  input  logic               clk,
  input  logic               rst,
  input  u8flt_pkg::entry_t  head,
  input  logic               q_empty,
  output logic               pop,
  output logic               mid_entry,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               cyrillic_seen
);
  import u8flt_pkg::*;

  logic       second;
  logic       load;
  logic       emit;
  logic       final_slot;
  slot_t      cur;
  logic [7:0] cur_byte;

  assign load       = !m_tvalid || m_tready;
  assign emit       = load && !q_empty;
  assign cur        = second ? head.s1 : head.s0;
  assign cur_byte   = cur.conv ? utf8_convert(cur.lead, cur.data) : cur.data;
  assign final_slot = second || !head.two;
  assign pop        = emit && final_slot;
  assign mid_entry  = second;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second   <= 1'b0;
    end else if (load) begin
      m_tvalid <= !q_empty;
      if (emit) begin
        second <= !final_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= cur_byte;
      out_last      <= head.last && final_slot;
      cyrillic_seen <= head.cyr;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/utf8_to_latin1_cp1251_filter_unit.sv @@
// Top level of the UTF-8 to Latin-1 / Windows-1251 text filter.
// Depends on u8flt_pkg, u8flt_front, u8flt_queue, u8flt_back and the assert header.
//
//   Channel   Direction  Contents
//   s_*       in         tdata = in_byte[7:0], tlast = is_last, tuser = clear_flag
//   m_*       out        tdata = out_byte[7:0], tlast = out_last, tuser = cyrillic_seen
//
// A byte is taken every cycle while the queue has room.
// An item that yields two characters is sent as two output bytes, one per
// character; the output therefore sets the sustained rate for such items.
// An input byte passes through the queue and then the output register.
// Reset clears the held escape and lead state, the Cyrillic flag and the queue.
`default_nettype none
`include "utf8_to_latin1_cp1251_filter_unit_assert.svh"

module utf8_to_latin1_cp1251_filter_unit #(
  parameter int unsigned QueueDepth = u8flt_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte[7:0]
  input  logic       s_tlast,
  input  logic       s_tuser,   // clear_flag
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte[7:0]
  output logic       m_tlast,
  output logic       m_tuser    // cyrillic_seen
);
  import u8flt_pkg::*;

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          mid_entry;
  entry_t        push_entry;
  entry_t        head;
  front_status_t front_status;

  u8flt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_byte    (s_tdata),
    .is_last    (s_tlast),
    .clear_flag (s_tuser),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry),
    .status     (front_status)
  );

  u8flt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  u8flt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .mid_entry     (mid_entry),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_byte      (m_tdata),
    .out_last      (m_tlast),
    .cyrillic_seen (m_tuser)
  );

  `U8FLT_ASSERT_ALWAYS(a_no_overflow, !(push && q_full), "entry pushed into a full queue")
  `U8FLT_ASSERT_ALWAYS(a_mid_entry, !mid_entry || (!q_empty && head.two), "second character without a two-character entry")
  `U8FLT_ASSERT_NEXT(a_flush, s_tvalid && s_tready && s_tlast, !front_status.hold_bs && !front_status.hold_lead, "state held after the last byte of a string")

endmodule

`default_nettype wire
